// ===== rtl/core/xcfp_pkg.sv =====
// ---------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checked frame parser: parser
// states, controller/datapath command and status bundles, register codes.
// ---------------------------------------------------------------------------
package xcfp_pkg;

  // default payload capacity in bytes (1 to 63)
  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 32;

  // configuration register map
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC = 2'd1;

  // register reset values
  localparam logic [7:0] FIRST_SYNC_RST  = 8'hAA;
  localparam logic [7:0] SECOND_SYNC_RST = 8'h55;

  // width of the frame_length result field
  localparam int unsigned FRAME_LEN_W = 6;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_SECOND,
    ST_LENGTH,
    ST_COMMAND,
    ST_PAYLOAD,
    ST_CHECK,
    ST_EMIT
  } parse_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_len;
    logic take_cmd;
    logic take_pay;
    logic start_emit;
    logic emit_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic b_first;
    logic b_second;
    logic len_ok;
    logic len_short;
    logic pay_last;
    logic sum_ok;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/xcfp_ctrl.sv =====
// ---------------------------------------------------------------------------
// xcfp_ctrl
// Parser sequencer: walks sync, length, command, payload and checksum
// phases, then drives the result drain one result per free output slot.
// ---------------------------------------------------------------------------
module xcfp_ctrl
  import xcfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  parse_state_t state;
  parse_state_t state_next;
  logic         in_acc;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FIRST;
    end else begin
      state <= state_next;
    end
  end

  // input is held off only while a frame drains
  assign in_stall = (state == ST_EMIT);
  assign in_acc   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_FIRST: begin
        if (in_acc && sts.b_first) state_next = ST_SECOND;
      end
      ST_SECOND: begin
        // second sync wins over a repeated first sync
        if (in_acc) begin
          if (sts.b_second) begin
            state_next = ST_LENGTH;
          end else if (!sts.b_first) begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_LENGTH: begin
        if (in_acc) begin
          if (sts.len_ok) begin
            cmd.take_len = 1'b1;
            state_next   = ST_COMMAND;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_COMMAND: begin
        if (in_acc) begin
          cmd.take_cmd = 1'b1;
          state_next   = sts.len_short ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          cmd.take_pay = 1'b1;
          if (sts.pay_last) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          if (sts.sum_ok) begin
            cmd.start_emit = 1'b1;
            state_next     = ST_EMIT;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) state_next = ST_FIRST;
        end
      end
      default: begin
        state_next = ST_FIRST;
      end
    endcase
  end

  // checks
  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && sts.emit_last) |=> (state == ST_FIRST))
    else $error("parser did not return to hunt after last result");

  a_bad_sum_drops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && in_acc && !sts.sum_ok) |=> (state == ST_FIRST))
    else $error("frame with bad checksum not dropped");

endmodule

// ===== rtl/core/xcfp_dp.sv =====
// ---------------------------------------------------------------------------
// xcfp_dp
// Parser datapath: sync registers, frame header registers, running XOR,
// payload store and the result output register.
// ---------------------------------------------------------------------------
module xcfp_dp
  import xcfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             rx_byte,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_command,
  output logic [FRAME_LEN_W-1:0] frame_length,
  output logic [7:0]             payload_byte,
  output logic                   byte_present,
  output logic                   last_of_frame
);

  // length byte reaches MAX+1, byte counts reach MAX
  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD_BYTES + 2);
  localparam int unsigned IDX_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

  logic [7:0]       first_sync;
  logic [7:0]       second_sync;
  logic [LEN_W-1:0] len_q;
  logic [7:0]       cmd_q;
  logic [7:0]       xor_q;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] plen;
  logic [7:0]       store [MAX_PAYLOAD_BYTES];

  // configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RST;
      second_sync <= SECOND_SYNC_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FIRST_SYNC)  first_sync  <= cfg_data;
      if (cfg_index == CFG_SECOND_SYNC) second_sync <= cfg_data;
    end
  end

  // frame header, checksum accumulator, write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      len_q  <= '0;
      cmd_q  <= 8'd0;
      xor_q  <= 8'd0;
      wr_idx <= '0;
    end else begin
      if (cmd.take_len) begin
        len_q <= rx_byte[LEN_W-1:0];
        xor_q <= rx_byte;
      end
      if (cmd.take_cmd) begin
        cmd_q  <= rx_byte;
        xor_q  <= xor_q ^ rx_byte;
        wr_idx <= '0;
      end
      if (cmd.take_pay) begin
        xor_q  <= xor_q ^ rx_byte;
        wr_idx <= wr_idx + 1'b1;
      end
    end
  end

  // payload store write port
  always_ff @(posedge clk) begin
    if (cmd.take_pay) store[wr_idx[ADDR_W-1:0]] <= rx_byte;
  end

  assign plen = IDX_W'(len_q - 1'b1);

  // status to the controller
  always_comb begin
    sts.b_first   = (rx_byte == first_sync);
    sts.b_second  = (rx_byte == second_sync);
    sts.len_ok    = (rx_byte != 8'd0) && (rx_byte <= 8'(MAX_PAYLOAD_BYTES + 1));
    sts.len_short = (len_q <= LEN_W'(1));
    sts.pay_last  = ((LEN_W+1)'(wr_idx) + (LEN_W+1)'(2)) >= (LEN_W+1)'(len_q);
    sts.sum_ok    = (rx_byte == xor_q);
    sts.emit_last = sts.len_short || ((rd_idx + 1'b1) == plen);
    sts.out_free  = !out_valid || !out_stall;
  end

  // read pointer for the drain
  always_ff @(posedge clk) begin
    if (cmd.start_emit) begin
      rd_idx <= '0;
    end else if (cmd.emit_load) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // output register, payload read straight from the store
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      frame_command <= cmd_q;
      last_of_frame <= sts.emit_last;
      if (sts.len_short) begin
        frame_length <= '0;
        payload_byte <= 8'd0;
        byte_present <= 1'b0;
      end else begin
        frame_length <= FRAME_LEN_W'(plen);
        payload_byte <= store[rd_idx[ADDR_W-1:0]];
        byte_present <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while still held");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take_pay |-> (wr_idx < IDX_W'(MAX_PAYLOAD_BYTES)))
    else $error("payload write beyond store");

endmodule

// ===== rtl/core/xor_checked_frame_parser.sv =====
// ---------------------------------------------------------------------------
// xor_checked_frame_parser
// Byte-serial receiver for sync/sync/length/command/payload/checksum frames.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, rx_byte) takes one received byte per
//   transaction. Bytes are taken one per cycle in every phase except while
//   a good frame drains, when in_stall is held high.
//   Output channel (out_valid/out_stall) gives one transaction per payload
//   byte, or a single empty one (byte_present low) for a frame without
//   payload; last_of_frame marks the end. Bad frames give nothing.
//   Drain: the first result is loaded into the output register from the
//   drain state entered on the checksum byte; results then follow one per
//   cycle while the receiver does not stall, set by the single read port
//   of the payload store. Receiver stall holds the current result and
//   pauses the drain.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 is the first sync byte, 1 the second, others ignored.
//   Reset: synchronous, sync bytes return to 0xAA/0x55, parser hunts for
//   the first sync byte and the output is empty.
// ---------------------------------------------------------------------------
module xor_checked_frame_parser
  import xcfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_command,
  output logic [FRAME_LEN_W-1:0] frame_length,
  output logic [7:0]             payload_byte,
  output logic                   byte_present,
  output logic                   last_of_frame
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  xcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  xcfp_dp #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .byte_present  (byte_present),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== tb/sv/tb_xor_checked_frame_parser.sv =====
// ---------------------------------------------------------------------------
// tb_xor_checked_frame_parser
// Self-checking bench for the XOR-checked frame parser. Received bytes go in
// one transaction at a time and are tracked by a byte-level copy of the
// parser, which queues the payload results each good frame must produce.
// Every output transaction is compared field by field with the oldest queued
// result. Directed frames and sync register settings come first, then a
// random mix of good, corrupted and stray traffic with random idling on both
// channels.
// ---------------------------------------------------------------------------
module tb_xor_checked_frame_parser;
  import xcfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES      = MAX_PAYLOAD_BYTES_DEF;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // index with no register behind it, writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0]             command;
    logic [FRAME_LEN_W-1:0] length;
    logic [7:0]             data;
    logic                   present;
    logic                   last;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = 8'h00;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             frame_command;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic [7:0]             payload_byte;
  logic                   byte_present;
  logic                   last_of_frame;

  // bench copy of the parser state and sync registers
  logic [7:0]    sync_first;
  logic [7:0]    sync_second;
  parse_state_t  phase;
  logic [7:0]    len_byte;
  logic [7:0]    cmd_hold;
  logic [7:0]    sum;
  int unsigned   idx;
  logic [7:0]    rx_store [MAX_BYTES];

  frame_result_t payload_due [$];
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_run = 0;
  logic          calm = 1'b0;

  xor_checked_frame_parser #(
    .MAX_PAYLOAD_BYTES(MAX_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_command(frame_command),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .byte_present (byte_present),
    .last_of_frame(last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --- parser tracking ------------------------------------------------------

  function automatic void reset_tracker();
    sync_first  = FIRST_SYNC_RST;
    sync_second = SECOND_SYNC_RST;
    phase       = ST_FIRST;
    len_byte    = 8'h00;
    cmd_hold    = 8'h00;
    sum         = 8'h00;
    idx         = 0;
  endfunction

  // advance the tracked parser by one accepted byte, queue any results
  function automatic void track_rx_byte(input logic [7:0] b);
    frame_result_t r;
    int unsigned   plen;
    case (phase)
      ST_FIRST: begin
        if (b == sync_first) phase = ST_SECOND;
      end
      ST_SECOND: begin
        // second sync checked first, so it wins when both are equal
        if (b == sync_second) phase = ST_LENGTH;
        else if (b != sync_first) phase = ST_FIRST;
      end
      ST_LENGTH: begin
        if (b == 8'h00 || b > MAX_BYTES + 1) begin
          phase = ST_FIRST;
        end else begin
          len_byte = b;
          sum      = b;
          phase    = ST_COMMAND;
        end
      end
      ST_COMMAND: begin
        cmd_hold = b;
        sum      = sum ^ b;
        idx      = 0;
        phase    = (len_byte <= 1) ? ST_CHECK : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (idx < MAX_BYTES) rx_store[idx] = b;
        sum = sum ^ b;
        idx++;
        if (idx + 1 >= len_byte || idx >= MAX_BYTES) phase = ST_CHECK;
      end
      ST_CHECK: begin
        phase = ST_FIRST;
        // bad checksum: frame dropped without a word
        if (b == sum) begin
          plen = len_byte - 1;
          if (plen > MAX_BYTES) plen = MAX_BYTES;
          if (plen == 0) begin
            r.command = cmd_hold;
            r.length  = '0;
            r.data    = 8'h00;
            r.present = 1'b0;
            r.last    = 1'b1;
            payload_due.push_back(r);
          end else begin
            for (int unsigned k = 0; k < plen; k++) begin
              r.command = cmd_hold;
              r.length  = FRAME_LEN_W'(plen);
              r.data    = rx_store[k];
              r.present = 1'b1;
              r.last    = (k + 1 == plen);
              payload_due.push_back(r);
            end
          end
        end
      end
      default: phase = ST_FIRST;
    endcase
  endfunction

  // --- idling ----------------------------------------------------------------

  // mostly short, now and then long
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_span();
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run = idle_span() - 1;
    end else begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 5);
    end
  end

  // --- checking --------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (mismatches < 40)
      $display("%0t: %s mismatch, got 0x%02h, want 0x%02h", $time, what, got, want);
    mismatches++;
  endtask

  // each output transaction against the oldest queued result
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (payload_due.size() == 0) begin
        flag_mismatch("result with nothing pending:", payload_byte, 8'h00);
      end else begin
        want = payload_due.pop_front();
        if (frame_command !== want.command)
          flag_mismatch("frame_command", frame_command, want.command);
        if (frame_length !== want.length)
          flag_mismatch("frame_length", 8'(frame_length), 8'(want.length));
        if (payload_byte !== want.data)
          flag_mismatch("payload_byte", payload_byte, want.data);
        if (byte_present !== want.present)
          flag_mismatch("byte_present", 8'(byte_present), 8'(want.present));
        if (last_of_frame !== want.last)
          flag_mismatch("last_of_frame", 8'(last_of_frame), 8'(want.last));
      end
    end
  end

  // cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --- drivers ---------------------------------------------------------------

  // one input transaction, returns in the step it is taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
    items_sent++;
  endtask

  // hold input off until every queued result is out, then let the parser settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (payload_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; end_writes drops it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_FIRST_SYNC:  sync_first  = value;
      CFG_SECOND_SYNC: sync_second = value;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // full frame with the current sync bytes; bad lengths stop after the length
  task automatic send_frame(input logic [7:0] len, input bit sum_good);
    logic [7:0] cmd;
    logic [7:0] pay;
    logic [7:0] chk;
    send_byte(sync_first);
    send_byte(sync_second);
    send_byte(len);
    if (len == 8'h00 || len > MAX_BYTES + 1) return;
    cmd = 8'($urandom_range(0, 255));
    chk = len ^ cmd;
    send_byte(cmd);
    repeat (len - 1) begin
      pay = 8'($urandom_range(0, 255));
      chk = chk ^ pay;
      send_byte(pay);
    end
    if (!sum_good) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // --- tests -----------------------------------------------------------------

  // frame with no payload: one empty result
  task automatic test_empty_frame();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFE);
  endtask

  // first sync repeated while waiting for the second
  task automatic test_repeated_sync();
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h02);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(8'hA7);
  endtask

  // zero length, length one past the limit, checksum mismatch
  task automatic test_bad_frames();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'(MAX_BYTES + 2));
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h02);
    send_byte(8'h7E);
    send_byte(8'h81);
    send_byte(8'h00);
  endtask

  // sync registers at extremes, equal values, and a write to the spare index
  task automatic test_sync_registers();
    wait_drained();
    write_reg(CFG_FIRST_SYNC, 8'h00);
    write_reg(CFG_SECOND_SYNC, 8'hFF);
    end_writes();
    send_frame(8'h02, 1'b1);
    send_frame(8'h01, 1'b1);
    wait_drained();
    write_reg(CFG_FIRST_SYNC, 8'hFF);
    write_reg(CFG_SECOND_SYNC, 8'h00);
    write_reg(CFG_SPARE, 8'h5A);
    end_writes();
    send_frame(8'h03, 1'b1);
    wait_drained();
    write_reg(CFG_FIRST_SYNC, 8'h3C);
    write_reg(CFG_SECOND_SYNC, 8'h3C);
    end_writes();
    // equal syncs: the second byte opens the length phase
    send_frame(8'h02, 1'b1);
    send_frame(8'h01, 1'b1);
    wait_drained();
    write_reg(CFG_FIRST_SYNC, FIRST_SYNC_RST);
    write_reg(CFG_SECOND_SYNC, SECOND_SYNC_RST);
    end_writes();
  endtask

  task automatic test_longest_frame();
    send_frame(8'(MAX_BYTES + 1), 1'b1);
  endtask

  // mostly good frames, the rest corrupted or stray bytes
  task automatic run_mix(input int unsigned goal);
    int unsigned r;
    logic [7:0]  len;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 6) len = 8'(MAX_BYTES + 1);
        else if (r < 20) len = 8'($urandom_range(1, MAX_BYTES + 1));
        else len = 8'($urandom_range(1, 6));
        send_frame(len, 1'b1);
      end else if (r < 80) begin
        send_frame(8'($urandom_range(1, 8)), 1'b0);
      end else if (r < 87) begin
        if ($urandom_range(0, 1) == 0) len = 8'h00;
        else len = 8'($urandom_range(MAX_BYTES + 2, 255));
        send_frame(len, 1'b1);
      end else if (r < 93) begin
        send_byte(sync_first);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      // sender backs off until the output has fully drained
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  task automatic test_random_frames();
    calm <= 1'b1;
    run_mix(110);
    wait_drained();
    write_reg(CFG_FIRST_SYNC, 8'($urandom_range(0, 255)));
    write_reg(CFG_SECOND_SYNC, 8'($urandom_range(0, 255)));
    end_writes();
    calm <= 1'b0;
    run_mix(160);
    wait_drained();
    write_reg(CFG_FIRST_SYNC, 8'($urandom_range(0, 255)));
    write_reg(CFG_SECOND_SYNC, 8'($urandom_range(0, 255)));
    end_writes();
    run_mix(210);
  endtask

  initial begin
    reset_tracker();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_frame();
    test_repeated_sync();
    test_bad_frames();
    test_sync_registers();
    test_longest_frame();
    test_random_frames();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== xor_checked_frame_parser.f =====
rtl/core/xcfp_pkg.sv
rtl/core/xcfp_ctrl.sv
rtl/core/xcfp_dp.sv
rtl/core/xor_checked_frame_parser.sv
tb/sv/tb_xor_checked_frame_parser.sv
